// ----- src/dvfu_pkg.sv -----
package dvfu_pkg;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 64;
  localparam int unsigned ValW    = 16;
  localparam int unsigned FloorW  = 40;
  localparam int unsigned DsqW    = 32;
  localparam int unsigned GsqW    = 31;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned MagW    = 48;
  localparam int unsigned DenW    = 49;
  localparam int unsigned DvsW    = DenW + 1;
  localparam int unsigned RemW    = 57;
  localparam int unsigned QuoW    = 17;
  localparam int unsigned WideW   = DvsW + QuoW;
  localparam int unsigned SumW    = 19;
  localparam int unsigned DivRegs = QuoW + 2;
  localparam int unsigned NumStg  = 4 + DivRegs + 1;

  localparam logic [1:0] RegHomog = 2'd0;
  localparam logic [1:0] RegAccel = 2'd1;
  localparam logic [1:0] RegFloor = 2'd2;

  localparam logic [ValW-1:0]   HomogRst = 16'hFFFF;
  localparam logic [ValW-1:0]   AccelRst = 16'd256;
  localparam logic [FloorW-1:0] FloorRst = 40'd1;

  typedef struct packed {
    logic                        diff_neg;
    logic [ValW-1:0]             diff_mag;
    logic [2:0]                  g_neg;
    logic [2:0][ValW-1:0]        g_mag;
    logic [2:0][GsqW-1:0]        g_sq;
    logic [2:0][ValW-1:0]        disp;
    logic                        inl;
  } s1_t;

  typedef struct packed {
    logic [DsqW-1:0]             dsq;
    logic [DsqW-1:0]             gsum;
    logic [2:0][ProdW-1:0]       pm;
    logic [2:0]                  neg;
    logic [2:0][ValW-1:0]        disp;
    logic                        inl;
  } s2_t;

  typedef struct packed {
    logic [MagW-1:0]             hd;
    logic [DsqW-1:0]             gsum;
    logic [DsqW-1:0]             dsq;
    logic [2:0][MagW-1:0]        mg;
    logic [2:0]                  neg;
    logic [2:0][ValW-1:0]        disp;
    logic                        inl;
  } s3_t;

  typedef struct packed {
    logic [DenW-1:0]             den;
    logic [DsqW-1:0]             dsq;
    logic [2:0][MagW-1:0]        mg;
    logic [2:0]                  neg;
    logic [2:0][ValW-1:0]        disp;
    logic                        inl;
  } s4_t;

  typedef struct packed {
    logic [2:0][RemW-1:0]        rem;
    logic [DvsW-1:0]             dvs;
    logic [2:0][QuoW-1:0]        quo;
    logic [2:0]                  ovf;
    logic [2:0]                  neg;
    logic [2:0][ValW-1:0]        disp;
    logic                        inl;
    logic                        upd;
    logic                        zero;
    logic [DsqW-1:0]             dsq;
  } div_t;

endpackage

// ----- src/demons_voxel_force_update.sv -----
// Demons voxel force update, one voxel per beat.
//
// Input channel (in_valid_i / in_ready_o) carries the fixed and moving
// intensities, the moving gradient, the current displacement and the
// in-bounds flag of one voxel. Output channel (out_valid_o / out_ready_i)
// returns the new saturated displacement, the inlier and update flags and
// diff squared for SSD statistics. One result beat per input beat, in order.
//
// The path from input beat to output beat runs through four multiply/add
// stages, two set-up stages for the divider, seventeen restoring divider
// stages (one quotient bit each, three lanes side by side) and the output
// register. Throughput is one beat per cycle while the receiver takes
// results; the divider chain is fully pipelined.
//
// Each stage moves on when the stage after it is empty or moving, so a
// stalled receiver holds only the stages that are full; bubbles close up and
// new beats are taken until every stage holds an item.
// Reset empties the pipeline and loads the register defaults. Configuration
// sits on an APB port (64-bit data, registers at 0x00, 0x08, 0x10).
module demons_voxel_force_update (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dvfu_pkg::AddrW-1:0]          paddr,
  input  logic [dvfu_pkg::DataW-1:0]          pwdata,
  output logic [dvfu_pkg::DataW-1:0]          prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [dvfu_pkg::ValW-1:0]    fixed_value_i,
  input  logic signed [dvfu_pkg::ValW-1:0]    moving_value_i,
  input  logic signed [dvfu_pkg::ValW-1:0]    grad_x_i,
  input  logic signed [dvfu_pkg::ValW-1:0]    grad_y_i,
  input  logic signed [dvfu_pkg::ValW-1:0]    grad_z_i,
  input  logic signed [dvfu_pkg::ValW-1:0]    disp_x_i,
  input  logic signed [dvfu_pkg::ValW-1:0]    disp_y_i,
  input  logic signed [dvfu_pkg::ValW-1:0]    disp_z_i,
  input  logic                                in_bounds_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dvfu_pkg::ValW-1:0]    est_x_o,
  output logic signed [dvfu_pkg::ValW-1:0]    est_y_o,
  output logic signed [dvfu_pkg::ValW-1:0]    est_z_o,
  output logic                                is_inlier_o,
  output logic                                was_updated_o,
  output logic [dvfu_pkg::DsqW-1:0]           diff_squared_o
);

  localparam int unsigned NumStg  = dvfu_pkg::NumStg;
  localparam int unsigned DivRegs = dvfu_pkg::DivRegs;
  localparam int unsigned OutStg  = NumStg - 1;
  localparam int unsigned ValW    = dvfu_pkg::ValW;
  localparam int unsigned SumW    = dvfu_pkg::SumW;
  localparam int unsigned QuoW    = dvfu_pkg::QuoW;
  localparam int unsigned WideW   = dvfu_pkg::WideW;
  localparam int unsigned RemW    = dvfu_pkg::RemW;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ValW-1:0]             homog_q;
  logic [ValW-1:0]             accel_q;
  logic [dvfu_pkg::FloorW-1:0] floor_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      homog_q <= dvfu_pkg::HomogRst;
      accel_q <= dvfu_pkg::AccelRst;
      floor_q <= dvfu_pkg::FloorRst;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        dvfu_pkg::RegHomog: homog_q <= pwdata[ValW-1:0];
        dvfu_pkg::RegAccel: accel_q <= pwdata[ValW-1:0];
        dvfu_pkg::RegFloor: floor_q <= pwdata[dvfu_pkg::FloorW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      dvfu_pkg::RegHomog: prdata = {48'b0, homog_q};
      dvfu_pkg::RegAccel: prdata = {48'b0, accel_q};
      dvfu_pkg::RegFloor: prdata = {24'b0, floor_q};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when it drains.
  // ---------------------------------------------------------------------
  logic [NumStg-1:0] v_q, v_d, rdy;

  always_comb begin
    rdy[OutStg] = ~v_q[OutStg] | out_ready_i;
    for (int k = OutStg - 1; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NumStg; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[OutStg];

  // ---------------------------------------------------------------------
  // Stage 1: intensity difference, magnitudes, gradient squares
  // ---------------------------------------------------------------------
  dvfu_pkg::s1_t s1_d, s1_q;
  logic signed [ValW:0]   diff;
  logic [2:0][ValW-1:0]   grad;

  assign grad = {grad_z_i, grad_y_i, grad_x_i};

  always_comb begin
    diff          = {fixed_value_i[ValW-1], fixed_value_i}
                  - {moving_value_i[ValW-1], moving_value_i};
    s1_d.diff_neg = diff[ValW];
    s1_d.diff_mag = diff[ValW] ? ValW'(-diff) : diff[ValW-1:0];
    for (int c = 0; c < 3; c++) begin
      s1_d.g_neg[c] = grad[c][ValW-1];
      s1_d.g_mag[c] = grad[c][ValW-1] ? (~grad[c] + 1'b1) : grad[c];
      s1_d.g_sq[c]  = dvfu_pkg::GsqW'({16'b0, s1_d.g_mag[c]} * {16'b0, s1_d.g_mag[c]});
    end
    s1_d.disp = {disp_z_i, disp_y_i, disp_x_i};
    s1_d.inl  = in_bounds_i;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: diff squared, gradient energy, |diff|*|g| per axis
  // ---------------------------------------------------------------------
  dvfu_pkg::s2_t s2_d, s2_q;

  always_comb begin
    s2_d.dsq  = {16'b0, s1_q.diff_mag} * {16'b0, s1_q.diff_mag};
    s2_d.gsum = {1'b0, s1_q.g_sq[0]} + {1'b0, s1_q.g_sq[1]} + {1'b0, s1_q.g_sq[2]};
    for (int c = 0; c < 3; c++) begin
      s2_d.pm[c]  = {16'b0, s1_q.diff_mag} * {16'b0, s1_q.g_mag[c]};
      s2_d.neg[c] = s1_q.diff_neg ^ s1_q.g_neg[c];
    end
    s2_d.disp = s1_q.disp;
    s2_d.inl  = s1_q.inl;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: weight diff squared, apply the step gain
  // ---------------------------------------------------------------------
  dvfu_pkg::s3_t s3_d, s3_q;

  always_comb begin
    s3_d.hd = {32'b0, homog_q} * {16'b0, s2_q.dsq};
    for (int c = 0; c < 3; c++) begin
      s3_d.mg[c] = {32'b0, accel_q} * {16'b0, s2_q.pm[c]};
    end
    s3_d.gsum = s2_q.gsum;
    s3_d.dsq  = s2_q.dsq;
    s3_d.neg  = s2_q.neg;
    s3_d.disp = s2_q.disp;
    s3_d.inl  = s2_q.inl;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s3_q <= s3_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: denominator
  // ---------------------------------------------------------------------
  dvfu_pkg::s4_t s4_d, s4_q;

  always_comb begin
    s4_d.den  = {1'b0, s3_q.hd} + {17'b0, s3_q.gsum};
    s4_d.dsq  = s3_q.dsq;
    s4_d.mg   = s3_q.mg;
    s4_d.neg  = s3_q.neg;
    s4_d.disp = s3_q.disp;
    s4_d.inl  = s3_q.inl;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s4_q <= s4_d;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: round(256*num/den) as floor((512*num + den) / (2*den)).
  // First register forms dividend and divisor, second flags quotients
  // beyond QuoW bits, then one quotient bit per register, MSB first.
  // ---------------------------------------------------------------------
  dvfu_pkg::div_t div_d [DivRegs];
  dvfu_pkg::div_t div_q [DivRegs];

  always_comb begin
    div_d[0]      = '0;
    div_d[0].dvs  = {s4_q.den, 1'b0};
    div_d[0].upd  = {9'b0, floor_q} <= s4_q.den;
    div_d[0].zero = s4_q.den == '0;
    for (int c = 0; c < 3; c++) begin
      div_d[0].rem[c] = {s4_q.mg[c], 9'b0} + {8'b0, s4_q.den};
    end
    div_d[0].neg  = s4_q.neg;
    div_d[0].disp = s4_q.disp;
    div_d[0].inl  = s4_q.inl;
    div_d[0].dsq  = s4_q.dsq;
  end

  always_comb begin
    logic [WideW-1:0] lim;
    lim      = WideW'(div_q[0].dvs) << QuoW;
    div_d[1] = div_q[0];
    for (int c = 0; c < 3; c++) begin
      div_d[1].ovf[c] = WideW'(div_q[0].rem[c]) >= lim;
    end
  end

  for (genvar j = 2; j < DivRegs; j++) begin : g_div
    localparam int unsigned Bit = DivRegs - 1 - j;
    always_comb begin
      logic [WideW-1:0] trial;
      logic             geq;
      trial    = WideW'(div_q[j-1].dvs) << Bit;
      div_d[j] = div_q[j-1];
      for (int c = 0; c < 3; c++) begin
        geq                  = WideW'(div_q[j-1].rem[c]) >= trial;
        div_d[j].quo[c][Bit] = geq;
        if (geq) begin
          div_d[j].rem[c] = div_q[j-1].rem[c] - trial[RemW-1:0];
        end
      end
    end
  end

  for (genvar j = 0; j < DivRegs; j++) begin : g_div_reg
    always_ff @(posedge clk_i) begin
      if (rdy[4+j]) begin
        div_q[j] <= div_d[j];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: sign, add to displacement, saturate
  // ---------------------------------------------------------------------
  dvfu_pkg::div_t           fin;
  logic [2:0][ValW-1:0]     est_d, est_q;
  logic                     inl_q, upd_q;
  logic [dvfu_pkg::DsqW-1:0] dsq_q;
  logic                     apply;

  assign fin   = div_q[DivRegs-1];
  assign apply = fin.inl & fin.upd & ~fin.zero;

  always_comb begin
    logic [QuoW-1:0]        q;
    logic signed [SumW-1:0] delta;
    logic signed [SumW-1:0] sum;
    for (int c = 0; c < 3; c++) begin
      q     = fin.ovf[c] ? {QuoW{1'b1}} : fin.quo[c];
      delta = fin.neg[c] ? -$signed({2'b0, q}) : $signed({2'b0, q});
      sum   = $signed({{(SumW-ValW){fin.disp[c][ValW-1]}}, fin.disp[c]}) + delta;
      if (!apply) begin
        est_d[c] = fin.disp[c];
      end else if (sum > $signed(SumW'(32767))) begin
        est_d[c] = 16'h7FFF;
      end else if (sum < -$signed(SumW'(32768))) begin
        est_d[c] = 16'h8000;
      end else begin
        est_d[c] = sum[ValW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[OutStg]) begin
      est_q <= est_d;
      inl_q <= fin.inl;
      upd_q <= fin.inl & fin.upd;
      dsq_q <= fin.inl ? fin.dsq : '0;
    end
  end

  assign est_x_o        = est_q[0];
  assign est_y_o        = est_q[1];
  assign est_z_o        = est_q[2];
  assign is_inlier_o    = inl_q;
  assign was_updated_o  = upd_q;
  assign diff_squared_o = dsq_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_upd_needs_inlier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_updated_o |-> is_inlier_o)
    else $error("update flagged on an outlier");

  a_outlier_no_ssd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_inlier_o |-> diff_squared_o == '0)
    else $error("outlier reports nonzero diff squared");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && (&v_q))
    else $error("input blocked while pipeline has room");

  a_out_from_last_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v_q[OutStg-1]))
    else $error("result appeared without a divider item");

endmodule
